### hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and sizes of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [15:0] TOTAL_UNITS = 16'd1024;
	localparam logic [CNT_W-1:0] TABLE_FULL_CNT = CNT_W'(TABLE_ENTRIES);

	// Item kinds (slave tuser).
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Placement policies.
	localparam logic [1:0] POL_FIRST = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	// Result status codes (master tuser).
	localparam logic [2:0] STAT_ALLOC    = 3'd0;
	localparam logic [2:0] STAT_WAIT     = 3'd1;
	localparam logic [2:0] STAT_FREED    = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;
	localparam logic [2:0] STAT_READ     = 3'd5;

	// Register word index of the policy register.
	localparam logic REG_POLICY = 1'b0;

	typedef struct packed {
		logic        free;
		logic [7:0]  owner;
		logic [15:0] size;
	} entry_t;

	localparam entry_t RESET_ENTRY = '{free: 1'b1, owner: 8'd0, size: TOTAL_UNITS};

	typedef struct packed {
		logic clear;
		logic valid;
		logic op_free;
	} scan_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] pick;
		entry_t           entry;
	} scan_res_t;

endpackage

### hdl/pfa_scan.sv
// ----------------------------------------------------------------------------
// pfa_scan
// Candidate tracker: sees one table entry per beat, keeps the fit or tag pick.
// ----------------------------------------------------------------------------
module pfa_scan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pfa_pkg::scan_ctl_t       ctl,
	input  logic [1:0]               policy,
	input  logic [15:0]              req,
	input  logic [7:0]               tag,
	input  logic [pfa_pkg::IDX_W-1:0] idx,
	input  pfa_pkg::entry_t          entry,
	output pfa_pkg::scan_res_t       res
);

	logic        found_q;
	logic [pfa_pkg::IDX_W-1:0] pick_q;
	pfa_pkg::entry_t entry_q;
	logic [15:0] best_q;

	logic        fits;
	logic [15:0] waste;
	logic        take;

	always_comb begin
		fits  = entry.free && (entry.size >= req);
		waste = entry.size - req;
		take  = 1'b0;
		if (ctl.op_free) begin
			take = !found_q && !entry.free && (entry.owner == tag);
		end else begin
			case (policy)
				pfa_pkg::POL_FIRST: take = fits && !found_q;
				pfa_pkg::POL_BEST:  take = fits && (!found_q || waste < best_q);
				pfa_pkg::POL_WORST: take = fits && (!found_q || waste > best_q);
				default:            take = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.valid && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid && take && !ctl.clear) begin
			pick_q  <= idx;
			entry_q <= entry;
			best_q  <= waste;
		end
	end

	assign res = '{found: found_q, pick: pick_q, entry: entry_q};

endmodule

### hdl/partition_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_unit
// Partition table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                        Beat
//  s_*       in   tvalid tready tdata tuser      one request item
//  m_*       out  tvalid tready tdata tuser      one result item
//  APB       in   psel penable pwrite paddr ...  policy register
//
// An allocate or free item scans entries 0 to count - 1: the table memory
// is read one entry per cycle through its single read port, then a found
// pick is written back unless its split finds the table full, and a split
// appends the rest as a new entry. A read item reads one entry. No item is
// accepted before the last result is registered. Kind 3 is dropped on accept.
// After reset entry 0 reads as one free partition of the whole memory until
// it is first written; no clearing pass is needed. The next item is accepted
// while a result still waits on a stalled master side.
// ----------------------------------------------------------------------------
module partition_fit_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // tag_id[7:0], request_size[23:8], read_index[29:24]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // entry_index[5:0], entry_tag[13:6], entry_size[29:14],
	                               // entry_is_free[30], entry_exists[31], entry_count[38:32]
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = pfa_pkg::IDX_W;
	localparam int CNT_W = pfa_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FINISH, S_SPLIT, S_RDREQ, S_RDDATA, S_OUT
	} state_t;

	state_t state_q;

	logic [1:0]  policy_q;
	logic [1:0]  kind_q;
	logic [7:0]  tag_q;
	logic [15:0] req_q;
	logic [IDX_W-1:0] ridx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_i_q;
	logic [15:0] rest_q;
	logic        init0_q;

	logic [2:0]  res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [7:0]  res_tag_q;
	logic [15:0] res_size_q;
	logic        res_free_q;
	logic        res_exists_q;

	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	// Table memory.
	pfa_pkg::entry_t mem [pfa_pkg::TABLE_ENTRIES];
	pfa_pkg::entry_t rd_data_s1;
	logic        rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic        rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic        mem_we;
	logic [IDX_W-1:0] wr_addr;
	pfa_pkg::entry_t wr_data;
	pfa_pkg::entry_t rd_entry;

	pfa_pkg::scan_ctl_t scan_ctl;
	pfa_pkg::scan_res_t scan_res;

	logic        accept;
	logic        cfg_wr;
	logic        out_free;
	logic [15:0] rest;
	logic        need_split;
	logic        table_full;
	logic        is_alloc;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign is_alloc = (kind_q == pfa_pkg::KIND_ALLOC);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pfa_pkg::REG_POLICY);
	assign prdata = (paddr[2] == pfa_pkg::REG_POLICY) ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfa_pkg::POL_FIRST;
		end else if (cfg_wr) begin
			policy_q <= pwdata[1:0];
		end
	end

	// Entry 0 has not been written since reset until init0_q drops.
	assign rd_entry = (rd_idx_s1 == '0 && init0_q) ? pfa_pkg::RESET_ENTRY : rd_data_s1;

	assign rest       = scan_res.entry.size - req_q;
	assign table_full = (cnt_q >= pfa_pkg::TABLE_FULL_CNT);
	assign need_split = (rest != 16'd0);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_i_q[IDX_W-1:0];
		mem_we  = 1'b0;
		wr_addr = scan_res.pick;
		wr_data = '{free: 1'b1, owner: 8'd0, size: scan_res.entry.size};
		unique case (state_q)
			S_SCAN: begin
				rd_en = (scan_i_q < cnt_q);
			end
			S_RDREQ: begin
				rd_en   = 1'b1;
				rd_addr = ridx_q;
			end
			S_FINISH: begin
				if (is_alloc) begin
					mem_we  = scan_res.found && !(need_split && table_full);
					wr_data = '{free: 1'b0, owner: tag_q, size: req_q};
				end else begin
					mem_we = scan_res.found;
				end
			end
			S_SPLIT: begin
				mem_we  = 1'b1;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = '{free: 1'b1, owner: 8'd0, size: rest_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_v_s1 <= rd_en && (state_q == S_SCAN);
			if (rd_en) begin
				rd_idx_s1 <= rd_addr;
			end
		end
	end

	assign scan_ctl = '{clear: accept, valid: rd_v_s1, op_free: !is_alloc};

	pfa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.policy (policy_q),
		.req    (req_q),
		.tag    (tag_q),
		.idx    (rd_idx_s1),
		.entry  (rd_entry),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= pfa_pkg::KIND_ALLOC;
			tag_q        <= '0;
			req_q        <= '0;
			ridx_q       <= '0;
			cnt_q        <= CNT_W'(1);
			scan_i_q     <= '0;
			rest_q       <= '0;
			init0_q      <= 1'b1;
			res_status_q <= pfa_pkg::STAT_WAIT;
			res_idx_q    <= '0;
			res_tag_q    <= '0;
			res_size_q   <= '0;
			res_free_q   <= 1'b0;
			res_exists_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !(state_q == S_OUT && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			if (mem_we && wr_addr == '0) begin
				init0_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q   <= s_tuser;
						tag_q    <= s_tdata[7:0];
						req_q    <= s_tdata[23:8];
						ridx_q   <= s_tdata[29:24];
						scan_i_q <= '0;
						unique case (s_tuser) inside
							pfa_pkg::KIND_ALLOC, pfa_pkg::KIND_FREE: state_q <= S_SCAN;
							pfa_pkg::KIND_READ:                      state_q <= S_RDREQ;
							default:                                 state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					// The last entry is seen in the cycle after its read issues.
					if (scan_i_q < cnt_q) begin
						scan_i_q <= scan_i_q + CNT_W'(1);
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					res_exists_q <= scan_res.found;
					rest_q       <= rest;
					if (!scan_res.found) begin
						res_status_q <= is_alloc ? pfa_pkg::STAT_WAIT : pfa_pkg::STAT_NOTFOUND;
						res_idx_q    <= '0;
						res_tag_q    <= '0;
						res_size_q   <= '0;
						res_free_q   <= 1'b0;
						state_q      <= S_OUT;
					end else if (!is_alloc) begin
						res_status_q <= pfa_pkg::STAT_FREED;
						res_idx_q    <= scan_res.pick;
						res_tag_q    <= tag_q;
						res_size_q   <= scan_res.entry.size;
						res_free_q   <= 1'b1;
						state_q      <= S_OUT;
					end else if (need_split && table_full) begin
						// The picked entry is always free, so its tag reads as zero.
						res_status_q <= pfa_pkg::STAT_FULL;
						res_idx_q    <= scan_res.pick;
						res_tag_q    <= '0;
						res_size_q   <= scan_res.entry.size;
						res_free_q   <= 1'b1;
						state_q      <= S_OUT;
					end else begin
						res_status_q <= pfa_pkg::STAT_ALLOC;
						res_idx_q    <= scan_res.pick;
						res_tag_q    <= tag_q;
						res_size_q   <= req_q;
						res_free_q   <= 1'b0;
						state_q      <= need_split ? S_SPLIT : S_OUT;
					end
				end
				S_SPLIT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_OUT;
				end
				S_RDREQ: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					res_status_q <= pfa_pkg::STAT_READ;
					res_idx_q    <= ridx_q;
					if ({1'b0, ridx_q} < cnt_q) begin
						res_exists_q <= 1'b1;
						res_tag_q    <= rd_entry.free ? 8'd0 : rd_entry.owner;
						res_size_q   <= rd_entry.size;
						res_free_q   <= rd_entry.free;
					end else begin
						res_exists_q <= 1'b0;
						res_tag_q    <= '0;
						res_size_q   <= '0;
						res_free_q   <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {1'b0, cnt_q, res_exists_q, res_free_q, res_size_q,
						               res_tag_q, res_idx_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The table memory is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("table read and write overlap");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= pfa_pkg::TABLE_FULL_CNT)
		else $error("entry count out of range");

	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPLIT |-> !table_full && rest_q != 16'd0)
		else $error("split without room or remainder");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q == pfa_pkg::STAT_ALLOC |-> m_tdata_q[31] && !m_tdata_q[30])
		else $error("allocated result not reported as owned entry");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> $past(state_q) == S_SPLIT)
		else $error("entry count changed outside a split");

endmodule
